/* design/wcr_pkg.sv */
// ----------------------------------------------------------------------------
// wcr_pkg
// Shared constants and Q16.16 fixed-point helpers for the wave corrector
// right-hand-side pipeline.
// ----------------------------------------------------------------------------
package wcr_pkg;

   // Number of register stages from input capture to the output register
   localparam int WCR_DEPTH = 13;

   localparam logic signed [31:0] FX_ONE  = 32'sd65536;
   localparam logic signed [31:0] FX_ZERO = 32'sd0;
   localparam logic signed [31:0] FX_MAX  = 32'sh7fffffff;
   localparam logic signed [31:0] FX_MIN  = 32'sh80000000;

   localparam logic signed [63:0] LIM_HI = 64'sd2147483647;
   localparam logic signed [63:0] LIM_LO = -64'sd2147483648;

   // Control register indexes
   localparam logic [1:0] CSR_NONLINEAR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_SOUND_SPEED_SQ   = 2'd1;
   localparam logic [1:0] CSR_K_COEF           = 2'd2;
   localparam logic [1:0] CSR_JACOBIAN         = 2'd3;

   localparam logic [30:0] C2_RESET = 31'd65536;
   localparam logic [31:0] K_RESET  = 32'd0;
   localparam logic [31:0] J_RESET  = 32'd65536;

   function automatic logic signed [31:0] fx_sat33(input logic signed [32:0] v);
      logic signed [31:0] res;
      if (v[32] != v[31]) begin
         res = v[32] ? FX_MIN : FX_MAX;
      end else begin
         res = $signed(v[31:0]);
      end
      return res;
   endfunction

   function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      return fx_sat33(s);
   endfunction

   function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) - 33'(b);
      return fx_sat33(s);
   endfunction

   // Round half up (add 2^15, floor shift by 16), then clamp to 32 bits
   function automatic logic signed [31:0] fx_round(input logic signed [63:0] prod);
      logic signed [63:0] sh;
      logic signed [31:0] res;
      sh = (prod + 64'sd32768) >>> 16;
      if (sh > LIM_HI) begin
         res = FX_MAX;
      end else if (sh < LIM_LO) begin
         res = FX_MIN;
      end else begin
         res = $signed(sh[31:0]);
      end
      return res;
   endfunction

endpackage

/* design/wcr_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// wcr_pipe_ctrl
// Valid bits and per-stage advance enables for the datapath. A stage loads
// when it is empty or when the stage after it moves, so bubbles collapse.
// ----------------------------------------------------------------------------
module wcr_pipe_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [wcr_pkg::WCR_DEPTH:1] stage_en
);
   import wcr_pkg::*;

   logic [WCR_DEPTH:1] valid_ff;
   logic [WCR_DEPTH:1] valid_in;
   logic [WCR_DEPTH:1] valid_prev;

   assign valid_prev = {valid_ff[WCR_DEPTH-1:1], req_tvalid};

   genvar gi;
   generate
      for (gi = 1; gi <= WCR_DEPTH; gi++) begin : g_stage
         // moves when the output drains or a bubble sits at or after this stage
         assign stage_en[gi] = rsp_tready | ~(&valid_ff[WCR_DEPTH:gi]);
         assign valid_in[gi] = stage_en[gi] ? valid_prev[gi] : valid_ff[gi];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[1];
   assign rsp_tvalid = valid_ff[WCR_DEPTH];

endmodule

/* design/wcr_datapath.sv */
// ----------------------------------------------------------------------------
// wcr_datapath
// Thirteen-stage arithmetic pipeline. Stages 1, 3, 5, 7, 9 and 12 register
// raw 64-bit products, the following stage rounds, clamps and folds in the adds.
// ----------------------------------------------------------------------------
module wcr_datapath (
   input  logic                        clock,
   input  logic [wcr_pkg::WCR_DEPTH:1] stage_en,
   input  logic                        nonlinear_enable,
   input  logic [30:0]                 sound_speed_sq,
   input  logic signed [31:0]          k_coef,
   input  logic signed [31:0]          jacobian,
   input  logic signed [31:0]          grid_velocity,
   input  logic signed [31:0]          flow_velocity,
   input  logic signed [31:0]          geometry_factor,
   input  logic signed [31:0]          old_grad_phi,
   input  logic signed [31:0]          time_deriv_phi,
   input  logic signed [31:0]          grad_phi,
   input  logic signed [31:0]          lap_phi,
   input  logic                        last_point,
   output logic signed [31:0]          rhs,
   output logic                        last_out
);
   import wcr_pkg::*;

   logic signed [31:0] c2_pos;
   logic signed [31:0] neg_c2;
   logic signed [31:0] two_u;

   assign c2_pos = $signed({1'b0, sound_speed_sq});
   assign neg_c2 = -c2_pos;
   assign two_u  = fx_add(flow_velocity, flow_velocity);

   // stage 1
   logic signed [63:0] s1_tg_ff, s1_qog_ff, s1_uu_ff, s1_qq_ff, s1_jj_ff;
   logic signed [63:0] s1_ku_ff, s1_c2g_ff, s1_tuj_ff;
   logic signed [31:0] s1_q_ff, s1_u_ff, s1_two_u_ff, s1_dt_ff, s1_gr_ff, s1_lp_ff;
   logic               s1_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_tg_ff    <= jacobian * old_grad_phi;
         s1_qog_ff   <= grid_velocity * old_grad_phi;
         s1_uu_ff    <= flow_velocity * flow_velocity;
         s1_qq_ff    <= grid_velocity * grid_velocity;
         s1_jj_ff    <= jacobian * jacobian;
         s1_ku_ff    <= k_coef * flow_velocity;
         s1_c2g_ff   <= neg_c2 * geometry_factor;
         s1_tuj_ff   <= two_u * jacobian;
         s1_q_ff     <= grid_velocity;
         s1_u_ff     <= flow_velocity;
         s1_two_u_ff <= two_u;
         s1_dt_ff    <= time_deriv_phi;
         s1_gr_ff    <= grad_phi;
         s1_lp_ff    <= lap_phi;
         s1_last_ff  <= last_point;
      end
   end

   // stage 2
   logic signed [31:0] s2_tg_ff, s2_tdt_ff, s2_uu_ff, s2_al0_ff, s2_qq_ff, s2_jj_ff;
   logic signed [31:0] s2_ku_ff, s2_c2g_ff, s2_tuj_ff;
   logic signed [31:0] s2_q_ff, s2_u_ff, s2_two_u_ff, s2_gr_ff, s2_lp_ff;
   logic               s2_last_ff;
   logic signed [31:0] s2_uu_rnd;

   assign s2_uu_rnd = fx_round(s1_uu_ff);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s2_tg_ff    <= fx_round(s1_tg_ff);
         s2_tdt_ff   <= fx_add(s1_dt_ff, fx_round(s1_qog_ff));
         s2_uu_ff    <= s2_uu_rnd;
         s2_al0_ff   <= fx_sub(s2_uu_rnd, c2_pos);
         s2_qq_ff    <= fx_round(s1_qq_ff);
         s2_jj_ff    <= fx_round(s1_jj_ff);
         s2_ku_ff    <= fx_round(s1_ku_ff);
         s2_c2g_ff   <= fx_round(s1_c2g_ff);
         s2_tuj_ff   <= fx_round(s1_tuj_ff);
         s2_q_ff     <= s1_q_ff;
         s2_u_ff     <= s1_u_ff;
         s2_two_u_ff <= s1_two_u_ff;
         s2_gr_ff    <= s1_gr_ff;
         s2_lp_ff    <= s1_lp_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // stage 3
   logic signed [63:0] s3_ul_ff, s3_kut_ff, s3_uuu_ff, s3_nlt_ff, s3_blr_ff, s3_ktdt_ff;
   logic signed [31:0] s3_tg_ff, s3_qq_ff, s3_jj_ff, s3_al0_ff, s3_gr_ff, s3_lp_ff;
   logic               s3_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s3_ul_ff   <= s2_tuj_ff * s2_q_ff;
         s3_kut_ff  <= s2_ku_ff * s2_tg_ff;
         s3_uuu_ff  <= s2_uu_ff * s2_u_ff;
         s3_nlt_ff  <= s2_two_u_ff * s2_tg_ff;
         s3_blr_ff  <= s2_c2g_ff * jacobian;
         s3_ktdt_ff <= k_coef * s2_tdt_ff;
         s3_tg_ff   <= s2_tg_ff;
         s3_qq_ff   <= s2_qq_ff;
         s3_jj_ff   <= s2_jj_ff;
         s3_al0_ff  <= s2_al0_ff;
         s3_gr_ff   <= s2_gr_ff;
         s3_lp_ff   <= s2_lp_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // stage 4
   logic signed [31:0] s4_ul_ff, s4_a2_ff, s4_uuu_ff, s4_al1_ff, s4_blr_ff, s4_ktdt_ff;
   logic signed [31:0] s4_tg_ff, s4_qq_ff, s4_jj_ff, s4_gr_ff, s4_lp_ff;
   logic               s4_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s4_ul_ff   <= fx_round(s3_ul_ff);
         s4_a2_ff   <= fx_add(FX_ONE, fx_round(s3_kut_ff));
         s4_uuu_ff  <= fx_round(s3_uuu_ff);
         s4_al1_ff  <= nonlinear_enable ? fx_add(s3_al0_ff, fx_round(s3_nlt_ff))
                                        : s3_al0_ff;
         s4_blr_ff  <= fx_round(s3_blr_ff);
         s4_ktdt_ff <= fx_round(s3_ktdt_ff);
         s4_tg_ff   <= s3_tg_ff;
         s4_qq_ff   <= s3_qq_ff;
         s4_jj_ff   <= s3_jj_ff;
         s4_gr_ff   <= s3_gr_ff;
         s4_lp_ff   <= s3_lp_ff;
         s4_last_ff <= s3_last_ff;
      end
   end

   // stage 5
   logic signed [63:0] s5_kuuu_ff;
   logic signed [31:0] s5_b2_ff, s5_tg_ff, s5_al1_ff, s5_qq_ff, s5_jj_ff;
   logic signed [31:0] s5_ul_ff, s5_blr_ff, s5_gr_ff, s5_lp_ff;
   logic               s5_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s5_kuuu_ff <= k_coef * s4_uuu_ff;
         s5_b2_ff   <= fx_add(s4_a2_ff, s4_ktdt_ff);
         s5_tg_ff   <= s4_tg_ff;
         s5_al1_ff  <= s4_al1_ff;
         s5_qq_ff   <= s4_qq_ff;
         s5_jj_ff   <= s4_jj_ff;
         s5_ul_ff   <= s4_ul_ff;
         s5_blr_ff  <= s4_blr_ff;
         s5_gr_ff   <= s4_gr_ff;
         s5_lp_ff   <= s4_lp_ff;
         s5_last_ff <= s4_last_ff;
      end
   end

   // stage 6
   logic signed [31:0] s6_kuuu_ff, s6_b2_ff, s6_tg_ff, s6_al1_ff, s6_qq_ff, s6_jj_ff;
   logic signed [31:0] s6_ul_ff, s6_blr_ff, s6_gr_ff, s6_lp_ff;
   logic               s6_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         s6_kuuu_ff <= fx_round(s5_kuuu_ff);
         s6_b2_ff   <= s5_b2_ff;
         s6_tg_ff   <= s5_tg_ff;
         s6_al1_ff  <= s5_al1_ff;
         s6_qq_ff   <= s5_qq_ff;
         s6_jj_ff   <= s5_jj_ff;
         s6_ul_ff   <= s5_ul_ff;
         s6_blr_ff  <= s5_blr_ff;
         s6_gr_ff   <= s5_gr_ff;
         s6_lp_ff   <= s5_lp_ff;
         s6_last_ff <= s5_last_ff;
      end
   end

   // stage 7
   logic signed [63:0] s7_kuuut_ff, s7_b2qq_ff;
   logic signed [31:0] s7_al1_ff, s7_jj_ff, s7_ul_ff, s7_blr_ff, s7_gr_ff, s7_lp_ff;
   logic               s7_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         s7_kuuut_ff <= s6_kuuu_ff * s6_tg_ff;
         s7_b2qq_ff  <= s6_b2_ff * s6_qq_ff;
         s7_al1_ff   <= s6_al1_ff;
         s7_jj_ff    <= s6_jj_ff;
         s7_ul_ff    <= s6_ul_ff;
         s7_blr_ff   <= s6_blr_ff;
         s7_gr_ff    <= s6_gr_ff;
         s7_lp_ff    <= s6_lp_ff;
         s7_last_ff  <= s6_last_ff;
      end
   end

   // stage 8
   logic signed [31:0] s8_al2_ff, s8_b2qq_ff, s8_jj_ff, s8_ul_ff, s8_blr_ff;
   logic signed [31:0] s8_gr_ff, s8_lp_ff;
   logic               s8_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         s8_al2_ff  <= fx_add(s7_al1_ff, fx_round(s7_kuuut_ff));
         s8_b2qq_ff <= fx_round(s7_b2qq_ff);
         s8_jj_ff   <= s7_jj_ff;
         s8_ul_ff   <= s7_ul_ff;
         s8_blr_ff  <= s7_blr_ff;
         s8_gr_ff   <= s7_gr_ff;
         s8_lp_ff   <= s7_lp_ff;
         s8_last_ff <= s7_last_ff;
      end
   end

   // stage 9
   logic signed [63:0] s9_aljj_ff, s9_blrgr_ff;
   logic signed [31:0] s9_b2qq_ff, s9_ul_ff, s9_lp_ff;
   logic               s9_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[9]) begin
         s9_aljj_ff  <= s8_al2_ff * s8_jj_ff;
         s9_blrgr_ff <= s8_blr_ff * s8_gr_ff;
         s9_b2qq_ff  <= s8_b2qq_ff;
         s9_ul_ff    <= s8_ul_ff;
         s9_lp_ff    <= s8_lp_ff;
         s9_last_ff  <= s8_last_ff;
      end
   end

   // stage 10
   logic signed [31:0] s10_sum_ff, s10_blrgr_ff, s10_ul_ff, s10_lp_ff;
   logic               s10_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[10]) begin
         s10_sum_ff   <= fx_add(s9_b2qq_ff, fx_round(s9_aljj_ff));
         s10_blrgr_ff <= fx_round(s9_blrgr_ff);
         s10_ul_ff    <= s9_ul_ff;
         s10_lp_ff    <= s9_lp_ff;
         s10_last_ff  <= s9_last_ff;
      end
   end

   // stage 11: negation of BL
   logic signed [31:0] s11_nbl_ff, s11_blrgr_ff, s11_lp_ff;
   logic               s11_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[11]) begin
         s11_nbl_ff   <= fx_sub(FX_ZERO, fx_add(s10_sum_ff, s10_ul_ff));
         s11_blrgr_ff <= s10_blrgr_ff;
         s11_lp_ff    <= s10_lp_ff;
         s11_last_ff  <= s10_last_ff;
      end
   end

   // stage 12
   logic signed [63:0] s12_prod_ff;
   logic signed [31:0] s12_blrgr_ff;
   logic               s12_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[12]) begin
         s12_prod_ff  <= s11_nbl_ff * s11_lp_ff;
         s12_blrgr_ff <= s11_blrgr_ff;
         s12_last_ff  <= s11_last_ff;
      end
   end

   // stage 13: output register
   logic signed [31:0] s13_rhs_ff;
   logic               s13_last_ff;

   always_ff @(posedge clock) begin
      if (stage_en[13]) begin
         s13_rhs_ff  <= fx_sub(fx_round(s12_prod_ff), s12_blrgr_ff);
         s13_last_ff <= s12_last_ff;
      end
   end

   assign rhs      = s13_rhs_ff;
   assign last_out = s13_last_ff;

endmodule

/* design/wave_corrector_rhs_unit.sv */
// ----------------------------------------------------------------------------
// wave_corrector_rhs_unit
// Per-grid-point corrector right-hand side, rhs = -BL*lap - BLr*grad, Q16.16.
//
// Usage:
//  - req_ channel carries one grid point per transaction: seven Q16.16 fields
//    in req_tdata and the last-point mark in req_tlast.
//  - rsp_ channel returns the saturated rhs in rsp_tdata with the mark copied
//    to rsp_tlast, one transaction per point, in order.
//  - csr_ channel writes the four control registers (index 0..3); always ready.
//    Write them only while no points are in flight.
//  - Throughput: one point per cycle while the receiver does not stall. A
//    point passes through all 13 register stages before it shows on rsp_tvalid.
//    Depth is set by six dependent multiply levels, each a product register
//    followed by a round/clamp register, plus the stage-11 add register.
//  - When the receiver stalls, stages fill up behind the output register and
//    empty stages keep taking points; req_tready drops once every stage holds
//    data. Nothing is dropped or repeated.
//  - Reset (synchronous) empties the pipeline and restores the registers:
//    nonlinearity off, c0^2 = 1.0, K = 0, Jacobian = 1.0.
// ----------------------------------------------------------------------------
module wave_corrector_rhs_unit (
   input  logic         clock,
   input  logic         reset,
   // grid_velocity[31:0], flow_velocity[63:32], geometry_factor[95:64],
   // old_grad_phi[127:96], time_deriv_phi[159:128], grad_phi[191:160],
   // lap_phi[223:192]
   input  logic [223:0] req_tdata,
   input  logic         req_tlast,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rhs[31:0]
   output logic [31:0]  rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import wcr_pkg::*;

   logic               nonlinear_enable_ff;
   logic [30:0]        sound_speed_sq_ff;
   logic signed [31:0] k_coef_ff;
   logic signed [31:0] jacobian_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nonlinear_enable_ff <= 1'b0;
         sound_speed_sq_ff   <= C2_RESET;
         k_coef_ff           <= $signed(K_RESET);
         jacobian_ff         <= $signed(J_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NONLINEAR_ENABLE: nonlinear_enable_ff <= csr_data[0];
            CSR_SOUND_SPEED_SQ:   sound_speed_sq_ff   <= csr_data[30:0];
            CSR_K_COEF:           k_coef_ff           <= $signed(csr_data);
            CSR_JACOBIAN:         jacobian_ff         <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   logic [WCR_DEPTH:1] stage_en;

   wcr_pipe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stage_en   (stage_en)
   );

   logic signed [31:0] rhs;

   wcr_datapath u_datapath (
      .clock            (clock),
      .stage_en         (stage_en),
      .nonlinear_enable (nonlinear_enable_ff),
      .sound_speed_sq   (sound_speed_sq_ff),
      .k_coef           (k_coef_ff),
      .jacobian         (jacobian_ff),
      .grid_velocity    ($signed(req_tdata[31:0])),
      .flow_velocity    ($signed(req_tdata[63:32])),
      .geometry_factor  ($signed(req_tdata[95:64])),
      .old_grad_phi     ($signed(req_tdata[127:96])),
      .time_deriv_phi   ($signed(req_tdata[159:128])),
      .grad_phi         ($signed(req_tdata[191:160])),
      .lap_phi          ($signed(req_tdata[223:192])),
      .last_point       (req_tlast),
      .rhs              (rhs),
      .last_out         (rsp_tlast)
   );

   assign rsp_tdata = rhs;

endmodule

/* verif/wave_corrector_rhs_checker.sv */
// ----------------------------------------------------------------------------
// wave_corrector_rhs_checker
// Watches the req_, rsp_ and csr_ channels of the corrector right-hand-side
// unit. It keeps its own copy of the control registers, computes the expected
// Q16.16 rhs for every accepted grid point and compares each returned
// transaction, in order, against the oldest expected one.
// ----------------------------------------------------------------------------
module wave_corrector_rhs_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic [223:0] req_tdata,
   input  logic         req_tlast,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data,
   output int           pending,
   output int           fail_count
);
   import wcr_pkg::*;

   typedef logic signed [63:0] wide_type;

   // packed MSB first: matches the req_tdata layout, grid_vel in the low bits
   typedef struct packed {
      logic signed [31:0] lap;
      logic signed [31:0] grad;
      logic signed [31:0] dphi_dt;
      logic signed [31:0] old_grad;
      logic signed [31:0] geom;
      logic signed [31:0] flow_vel;
      logic signed [31:0] grid_vel;
   } grid_point_type;

   typedef struct {
      logic [31:0] rhs;
      logic        last;
   } rhs_result_type;

   rhs_result_type     expected_rhs[$];
   rhs_result_type     head;
   int                 failures = 0;

   logic               nl_en;
   logic [30:0]        c0_sq;
   logic signed [31:0] k_val;
   logic signed [31:0] jac;

   function automatic wide_type clamp_q(input wide_type v);
      if (v > LIM_HI) return LIM_HI;
      if (v < LIM_LO) return LIM_LO;
      return v;
   endfunction

   // exact product, round half up, floor shift, clamp
   function automatic wide_type mul_q(input wide_type a, input wide_type b);
      return clamp_q((a * b + 64'sd32768) >>> 16);
   endfunction

   function automatic wide_type add_q(input wide_type a, input wide_type b);
      return clamp_q(a + b);
   endfunction

   function automatic wide_type sub_q(input wide_type a, input wide_type b);
      return clamp_q(a - b);
   endfunction

   function automatic wide_type neg_q(input wide_type a);
      return clamp_q(-a);
   endfunction

   function automatic logic [31:0] corrector_rhs(input grid_point_type p);
      wide_type q, u, g, og, dt, gr, lp, c2, k, j;
      wide_type two_u, tg, tdt, ul, a2, b2, uu, al, bl, blr, rhs;
      q  = p.grid_vel;
      u  = p.flow_vel;
      g  = p.geom;
      og = p.old_grad;
      dt = p.dphi_dt;
      gr = p.grad;
      lp = p.lap;
      c2 = wide_type'({33'd0, c0_sq});
      k  = k_val;
      j  = jac;

      two_u = clamp_q(u + u);
      tg    = mul_q(j, og);
      tdt   = add_q(dt, mul_q(q, og));
      ul    = mul_q(mul_q(two_u, j), q);
      a2    = add_q(64'sd65536, mul_q(mul_q(k, u), tg));
      b2    = add_q(a2, mul_q(k, tdt));
      uu    = mul_q(u, u);
      al    = sub_q(uu, c2);
      if (nl_en) al = add_q(al, mul_q(two_u, tg));
      al    = add_q(al, mul_q(mul_q(k, mul_q(uu, u)), tg));
      bl    = add_q(add_q(mul_q(b2, mul_q(q, q)), mul_q(al, mul_q(j, j))), ul);
      blr   = mul_q(mul_q(neg_q(c2), g), j);
      rhs   = sub_q(mul_q(neg_q(bl), lp), mul_q(blr, gr));
      return rhs[31:0];
   endfunction

   task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
      failures++;
      if (failures <= 10)
         $display("mismatch %s: expected %h, got %h", what, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_rhs.delete();
         nl_en = 1'b0;
         c0_sq = C2_RESET;
         k_val = $signed(K_RESET);
         jac   = $signed(J_RESET);
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NONLINEAR_ENABLE: nl_en = csr_data[0];
               CSR_SOUND_SPEED_SQ:   c0_sq = csr_data[30:0];
               CSR_K_COEF:           k_val = $signed(csr_data);
               CSR_JACOBIAN:         jac   = $signed(csr_data);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rhs.size() == 0) begin
               flag("rhs with no point outstanding", 32'h0, rsp_tdata);
            end else begin
               head = expected_rhs.pop_front();
               if (rsp_tdata !== head.rhs) flag("rhs", head.rhs, rsp_tdata);
               if (rsp_tlast !== head.last) flag("last_out", 32'(head.last), 32'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            head.rhs  = corrector_rhs(grid_point_type'(req_tdata));
            head.last = req_tlast;
            expected_rhs.push_back(head);
         end
      end
      pending    <= expected_rhs.size();
      fail_count <= failures;
   end

endmodule

/* verif/wave_corrector_rhs_unit_tb.sv */
// ----------------------------------------------------------------------------
// wave_corrector_rhs_unit_tb
// Stimulus and verdict for the corrector right-hand-side unit. A directed set
// of extreme grid points is followed by random phases, each under a fresh
// register setting; all but two phases have random sender gaps and receiver
// stalls. Checking is done by wave_corrector_rhs_checker.
// ----------------------------------------------------------------------------
module wave_corrector_rhs_unit_tb;
   import wcr_pkg::*;

   localparam int PHASES           = 10;
   localparam int POINTS_PER_PHASE = 115;
   localparam int CYCLE_LIMIT      = 600000;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic [223:0] req_tdata  = '0;
   logic         req_tlast  = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index  = CSR_NONLINEAR_ENABLE;
   logic [31:0]  csr_data   = '0;

   int pending;
   int fail_count;
   int idle_pct    = 0;
   int stall_left  = 0;
   int cycle_count = 0;

   always #1 clock = ~clock;

   wave_corrector_rhs_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   wave_corrector_rhs_checker rhs_check (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver stalls in random bursts when idle_pct is nonzero
   always @(posedge clock) begin
      if (idle_pct == 0) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // mostly in-range magnitudes so the result does not always clamp
   function automatic logic [31:0] random_q();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = int'($urandom_range(0, 524287)) - 262144;
         4, 5:       v = int'($urandom_range(0, 32767)) - 16384;
         6, 7:       v = $urandom;
         8: begin
            case ($urandom_range(0, 4))
               0:       v = FX_MAX;
               1:       v = FX_MIN;
               2:       v = FX_ZERO;
               3:       v = FX_ONE;
               default: v = -FX_ONE;
            endcase
         end
         default:    v = int'($urandom_range(0, 33554431)) - 16777216;
      endcase
      return v;
   endfunction

   task automatic send_point(input logic [31:0] q, input logic [31:0] u,
                             input logic [31:0] g, input logic [31:0] og,
                             input logic [31:0] dt, input logic [31:0] gr,
                             input logic [31:0] lp, input logic last);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tdata  <= {lp, gr, dt, og, g, u, q};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(input logic end_of_sweep);
      send_point(random_q(), random_q(), random_q(), random_q(), random_q(),
                 random_q(), random_q(), end_of_sweep | ($urandom_range(0, 7) == 0));
   endtask

   // stop sending and wait for every outstanding point to come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (WCR_DEPTH + 2) @(posedge clock);
   endtask

   task automatic write_config(input logic [31:0] nl, input logic [31:0] c2,
                               input logic [31:0] k, input logic [31:0] j);
      logic [1:0]  idx  [4];
      logic [31:0] vals [4];
      int          i;
      idx  = '{CSR_NONLINEAR_ENABLE, CSR_SOUND_SPEED_SQ, CSR_K_COEF, CSR_JACOBIAN};
      vals = '{nl, c2, k, j};
      drain();
      for (i = 0; i < 4; i++) begin
         csr_index <= idx[i];
         csr_data  <= vals[i];
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes under the reset register values
      send_point(FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, 1'b0);
      send_point(FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE, 1'b0);
      send_point(FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b1);
      send_point(FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b0);
      send_point(FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, 1'b1);
      send_point(FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN, 1'b0);
      // stationary grid: q = 0 removes the UL and q*q terms
      send_point(FX_ZERO, FX_ONE, FX_ONE, FX_ONE, FX_ZERO, FX_ONE, FX_ONE, 1'b0);
      send_point(-FX_ONE, FX_ONE, -FX_ONE, FX_ONE, -FX_ONE, FX_ONE, -FX_ONE, 1'b1);
      repeat (4) send_random(1'b0);

      // local nonlinearity on, negative K and Jacobian
      write_config(32'd1, 32'h0002_0000, 32'hffff_8000, -FX_ONE);
      send_point(FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, 1'b0);
      send_point(FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE, 1'b1);
      send_point(FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b0);
      send_point(FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b1);
      repeat (2) send_random(1'b0);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       write_config(32'hffff_ffff, 32'hffff_ffff, FX_MAX, FX_MAX);
            1:       write_config(32'hffff_fffe, 32'h8000_0000, FX_MIN, FX_MIN);
            2:       write_config(32'd1, 32'(C2_RESET), FX_ZERO, FX_ZERO);
            default: write_config($urandom, ($urandom_range(0, 1) != 0) ? $urandom
                                  : (random_q() & 32'h007f_ffff), random_q(), random_q());
         endcase
         idle_pct = (p == 3 || p == PHASES - 1) ? 0 : $urandom_range(5, 40);
         for (int i = 0; i < POINTS_PER_PHASE; i++) begin
            send_random(i == POINTS_PER_PHASE - 1);
            if (p == 5 && i == POINTS_PER_PHASE / 2) drain();
         end
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
